// ===== sv/abe_pkg.sv =====
`timescale 1ns / 1ps
package abe_pkg;

  localparam int MAX_POINTS = 64;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    CMD_EVAL = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_DEL  = 3'd2,
    CMD_MOVE = 3'd3,
    CMD_SET  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_UPD  = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [30:0]        frame;
    logic [30:0]        target_frame;
    logic signed [31:0] point_value;
  } request_t;

  typedef struct packed {
    logic signed [31:0] level;
    logic               hit_valid;
    logic [30:0]        hit_frame;
    logic signed [31:0] hit_value;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic [30:0]        frm;
    logic signed [31:0] val;
  } entry_t;

  typedef struct packed {
    cell_op_t           op;
    logic [30:0]        key;
    logic signed [31:0] val;
  } cell_ctl_t;

  typedef struct packed {
    logic le;
    logic gt;
    logic eq;
  } cell_flag_t;

  typedef struct packed {
    logic               prev_ok;
    entry_t             prev;
    logic               next_ok;
    entry_t             next;
    logic               found;
    logic signed [31:0] found_val;
  } pick_t;

endpackage

// ===== sv/abe_cell.sv =====
`timescale 1ns / 1ps
module abe_cell (
  input  logic               clk,
  input  abe_pkg::cell_ctl_t ctl,
  input  logic               vld,
  input  abe_pkg::entry_t    left_ent,
  input  logic               left_gt,
  input  abe_pkg::entry_t    right_ent,
  output abe_pkg::entry_t    ent,
  output abe_pkg::cell_flag_t flag
);

  logic ge;

  always_comb begin
    flag.le = vld && (ent.frm <= ctl.key);
    flag.gt = !vld || (ent.frm > ctl.key);
    flag.eq = vld && (ent.frm == ctl.key);
    ge      = vld && (ent.frm >= ctl.key);
  end

  // Insert shifts the tail right, delete pulls it left.
  always_ff @(posedge clk) begin
    case (ctl.op)
      abe_pkg::OP_INS: begin
        if (flag.gt) begin
          if (left_gt) begin
            ent <= left_ent;
          end else begin
            ent <= '{frm: ctl.key, val: ctl.val};
          end
        end
      end
      abe_pkg::OP_DEL: begin
        if (ge) begin
          ent <= right_ent;
        end
      end
      abe_pkg::OP_UPD: begin
        if (flag.eq) begin
          ent.val <= ctl.val;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/abe_chain.sv =====
`timescale 1ns / 1ps
module abe_chain (
  input  logic                       clk,
  input  abe_pkg::cell_ctl_t         ctl,
  input  logic [abe_pkg::CNT_W-1:0]  count,
  output abe_pkg::pick_t             pick
);

  localparam int N = abe_pkg::MAX_POINTS;

  abe_pkg::entry_t     ents [N];
  abe_pkg::cell_flag_t flags [N];
  abe_pkg::entry_t     lent [N];
  abe_pkg::entry_t     rent [N];
  logic                lgt  [N];
  logic                vld  [N];
  logic                le_nx [N];
  logic                le_pv [N];

  function automatic logic [abe_pkg::CNT_W-1:0] CNT_W_EXT(input int v);
    CNT_W_EXT = v[abe_pkg::CNT_W-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < N; i++) begin
      vld[i]   = (CNT_W_EXT(i) < count);
      lent[i]  = (i == 0) ? '0 : ents[(i == 0) ? 0 : i - 1];
      lgt[i]   = (i == 0) ? 1'b0 : flags[(i == 0) ? 0 : i - 1].gt;
      le_pv[i] = (i == 0) ? 1'b1 : flags[(i == 0) ? 0 : i - 1].le;
      rent[i]  = (i == N - 1) ? '0 : ents[(i == N - 1) ? i : i + 1];
      le_nx[i] = (i == N - 1) ? 1'b0 : flags[(i == N - 1) ? i : i + 1].le;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    abe_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .vld       (vld[g]),
      .left_ent  (lent[g]),
      .left_gt   (lgt[g]),
      .right_ent (rent[g]),
      .ent       (ents[g]),
      .flag      (flags[g])
    );
  end

  // Neighbors of the search key and the matching point, one-hot selected.
  always_comb begin
    pick = '0;
    for (int i = 0; i < N; i++) begin
      if (flags[i].le && !le_nx[i]) begin
        pick.prev_ok = 1'b1;
        pick.prev    = pick.prev | ents[i];
      end
      if (vld[i] && !flags[i].le && le_pv[i]) begin
        pick.next_ok = 1'b1;
        pick.next    = pick.next | ents[i];
      end
      if (flags[i].eq) begin
        pick.found     = 1'b1;
        pick.found_val = pick.found_val | ents[i].val;
      end
    end
  end

endmodule

// ===== sv/automation_breakpoint_envelope.sv =====
`timescale 1ns / 1ps
// Breakpoint automation envelope.
// Issue a command by raising start with the request item while busy is low;
// the item is taken at that edge and busy rises on the next cycle.
// Commands: evaluate, add or update a point, delete, move a point, set the
// current level. Exactly one result item follows each command, shown for one
// cycle with done high; the receiver cannot stall, so take it then.
// A table edit searches the cells, then acts on them; a move searches
// again before it adds the point back. A linear evaluation also
// multiplies, runs the 33-step restoring divider that yields one quotient
// bit a cycle, and sums. One command is in flight at a time: busy drops
// the cycle after the result.
// The breakpoints live in a row of cells kept sorted by frame: an insert
// shifts the cells above the slot one step up, a delete pulls them down,
// and all cells compare against the key in the same cycle.
// Registers on the APB port, selected by paddr[3:2]: 0 automation_on,
// 1 step_mode, 2 default_value; write them only while busy is low.
// Reset (rst, synchronous) empties the table, zeroes the current level
// and all registers; table contents are not cleared and need no sweep.
module automation_breakpoint_envelope (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  abe_pkg::request_t request,
  output logic              busy,
  output logic              done,
  output abe_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CMP  = 8'b0000_0010,
    S_ACT  = 8'b0000_0100,
    S_MUL  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_SUM  = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_PICK = 8'b1000_0000
  } state_t;

  localparam logic [1:0] REG_ON   = 2'd0;
  localparam logic [1:0] REG_STEP = 2'd1;
  localparam logic [1:0] REG_DEF  = 2'd2;

  state_t                      state;
  state_t                      act_next;
  logic                        automation_on;
  logic                        step_mode;
  logic signed [31:0]          default_value;
  logic [abe_pkg::CNT_W-1:0]   count;
  logic signed [31:0]          cur_level;
  abe_pkg::cmd_t               job;
  logic [30:0]                 key;
  logic [30:0]                 tgt;
  logic signed [31:0]          val;
  abe_pkg::pick_t              pk;
  abe_pkg::pick_t              pick;
  abe_pkg::cell_ctl_t          ctl;
  logic                        hit_valid;
  logic [30:0]                 hit_frame;
  logic signed [31:0]          hit_value;
  logic [1:0]                  status;
  logic [30:0]                 dx;
  logic [30:0]                 dd;
  logic [31:0]                 mag;
  logic                        neg;
  logic signed [31:0]          v1;
  logic [32:0]                 low;
  logic [31:0]                 rem;
  logic [32:0]                 quo;
  logic [5:0]                  steps;
  logic [31:0]                 trial;
  logic                        cfg_wr;

  logic [30:0]        f1_w;
  logic signed [31:0] v1_w;
  logic signed [32:0] dv_w;
  logic signed [33:0] q_w;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign busy   = (state != S_IDLE);
  assign done   = (state == S_FIN);

  always_comb begin
    result.level     = cur_level;
    result.hit_valid = hit_valid;
    result.hit_frame = hit_frame;
    result.hit_value = hit_value;
    result.status    = status;
  end

  always_comb begin
    case (paddr[3:2])
      REG_ON:   prdata = {31'd0, automation_on};
      REG_STEP: prdata = {31'd0, step_mode};
      REG_DEF:  prdata = default_value;
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      automation_on <= 1'b0;
      step_mode     <= 1'b0;
      default_value <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ON:   automation_on <= pwdata[0];
        REG_STEP: step_mode     <= pwdata[0];
        REG_DEF:  default_value <= pwdata;
        default: begin
        end
      endcase
    end
  end

  abe_chain u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .count (count),
    .pick  (pick)
  );

  // Table edit issued to the cells in the action cycle.
  always_comb begin
    ctl.op  = abe_pkg::OP_HOLD;
    ctl.key = key;
    ctl.val = val;
    if (state == S_ACT) begin
      case (job)
        abe_pkg::CMD_ADD: begin
          if (pk.found) begin
            ctl.op = abe_pkg::OP_UPD;
          end else if (count < abe_pkg::CNT_W'(abe_pkg::MAX_POINTS)) begin
            ctl.op = abe_pkg::OP_INS;
          end
        end
        abe_pkg::CMD_DEL, abe_pkg::CMD_MOVE: begin
          if (pk.found) begin
            ctl.op = abe_pkg::OP_DEL;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Where the action cycle goes: divide for a linear evaluation, search
  // again for the second half of a move, else finish.
  always_comb begin
    act_next = S_FIN;
    case (job)
      abe_pkg::CMD_EVAL: begin
        if (automation_on && count != '0 && pk.next_ok && !step_mode) begin
          act_next = S_MUL;
        end
      end
      abe_pkg::CMD_MOVE: begin
        if (pk.found) begin
          act_next = S_PICK;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    f1_w  = pk.prev_ok ? pk.prev.frm : 31'd0;
    v1_w  = pk.prev_ok ? pk.prev.val : default_value;
    dv_w  = 33'(pk.next.val) - 33'(v1_w);
    trial = {rem[30:0], low[32]};
    q_w   = neg ? -34'(quo) : 34'(quo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cur_level <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            key       <= (request.cmd == abe_pkg::CMD_SET) ? '0 : request.frame;
            tgt       <= request.target_frame;
            val       <= request.point_value;
            hit_valid <= 1'b0;
            hit_frame <= '0;
            hit_value <= '0;
            status    <= abe_pkg::ST_OK;
            case (request.cmd)
              abe_pkg::CMD_EVAL: begin
                job   <= abe_pkg::CMD_EVAL;
                state <= S_CMP;
              end
              abe_pkg::CMD_ADD: begin
                job   <= abe_pkg::CMD_ADD;
                state <= S_CMP;
              end
              abe_pkg::CMD_DEL: begin
                job   <= abe_pkg::CMD_DEL;
                state <= S_CMP;
              end
              abe_pkg::CMD_MOVE: begin
                job   <= abe_pkg::CMD_MOVE;
                state <= S_CMP;
              end
              abe_pkg::CMD_SET: begin
                cur_level <= request.point_value;
                job       <= abe_pkg::CMD_ADD;
                state     <= (count < abe_pkg::CNT_W'(2)) ? S_CMP : S_FIN;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_CMP: begin
          pk    <= pick;
          state <= S_ACT;
        end
        S_ACT: begin
          state <= act_next;
          case (job)
            abe_pkg::CMD_EVAL: begin
              if (automation_on && count != '0) begin
                if (!pk.next_ok) begin
                  cur_level <= pk.prev.val;
                  hit_valid <= 1'b1;
                  hit_frame <= pk.prev.frm;
                  hit_value <= pk.prev.val;
                end else if (step_mode) begin
                  hit_valid <= 1'b1;
                  if (pk.prev_ok) begin
                    cur_level <= pk.prev.val;
                    hit_frame <= pk.prev.frm;
                    hit_value <= pk.prev.val;
                  end else begin
                    cur_level <= default_value;
                    hit_frame <= pk.next.frm;
                    hit_value <= pk.next.val;
                  end
                end else begin
                  dx    <= key - f1_w;
                  dd    <= pk.next.frm - f1_w;
                  v1    <= v1_w;
                  neg   <= dv_w[32];
                  mag   <= dv_w[32] ? 32'(-dv_w) : dv_w[31:0];
                end
              end
            end
            abe_pkg::CMD_ADD: begin
              if (!pk.found) begin
                if (count < abe_pkg::CNT_W'(abe_pkg::MAX_POINTS)) begin
                  count <= count + 1'b1;
                end else begin
                  status <= abe_pkg::ST_FULL;
                end
              end
            end
            abe_pkg::CMD_DEL: begin
              if (pk.found) begin
                count <= count - 1'b1;
              end else begin
                status <= abe_pkg::ST_NOTFOUND;
              end
            end
            abe_pkg::CMD_MOVE: begin
              if (pk.found) begin
                // Drop the point, then re-add its value at the target frame.
                count <= count - 1'b1;
                key   <= tgt;
                val   <= pk.found_val;
                job   <= abe_pkg::CMD_ADD;
              end else begin
                status <= abe_pkg::ST_NOTFOUND;
              end
            end
            default: begin
            end
          endcase
        end
        S_PICK: begin
          state <= S_CMP;
        end
        S_MUL: begin
          // Quotient fits in 33 bits, so the top 30 product bits start below dd.
          {rem, low} <= {2'b00, 63'(dx) * 63'(mag)};
          quo        <= '0;
          steps      <= 6'd33;
          state      <= S_DIV;
        end
        S_DIV: begin
          if (trial >= {1'b0, dd}) begin
            rem <= trial - {1'b0, dd};
            quo <= {quo[31:0], 1'b1};
          end else begin
            rem <= trial;
            quo <= {quo[31:0], 1'b0};
          end
          low   <= {low[31:0], 1'b0};
          steps <= steps - 1'b1;
          if (steps == 6'd1) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          cur_level <= 32'(34'(v1) + q_w);
          state     <= S_FIN;
        end
        S_FIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_frees: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy still high after result item");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= abe_pkg::CNT_W'(abe_pkg::MAX_POINTS))
    else $error("point count beyond table size");
  a_full_no_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACT && status == abe_pkg::ST_OK &&
     count == abe_pkg::CNT_W'(abe_pkg::MAX_POINTS) && job == abe_pkg::CMD_ADD &&
     !pk.found) |=> status == abe_pkg::ST_FULL)
    else $error("add to full table not flagged");

endmodule
